// File: hdl/rsem_pkg.sv
// Package with shared constants and controller/datapath types for the spacing estimator.
package rsem_pkg;
   localparam int MaxPoints  = 64;
   localparam int CoordBits  = 14;
   localparam int AddrBits   = $clog2(MaxPoints);
   localparam int CountBits  = $clog2(MaxPoints + 1);
   localparam int SumBits    = CoordBits + AddrBits;
   localparam int KeptBits   = 6;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [CountBits-1:0] count_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_GAP_RD, ST_GAP_WR,
      ST_MED_RD, ST_MED_WR, ST_DEV_RD, ST_DEV_WR, ST_MAD_RD, ST_MAD_WR,
      ST_KEEP_RD, ST_KEEP_ACC, ST_DIV, ST_ANCHOR_RD, ST_ANCHOR_WR, ST_OUT
   } state_type;

   // Which array the sort and median steps act on.
   typedef enum logic [1:0] {
      ARR_POINT, ARR_DEV
   } array_type;

   typedef struct packed {
      logic      store_point;
      logic      clear_set;
      logic      set_overflow;
      logic      rd_en;
      array_type arr;
      addr_type  addr_a;
      addr_type  addr_b;
      logic      swap_wr;
      logic      gap_wr;
      logic      dev_copy_wr;
      logic      dev_abs_wr;
      logic      med_lo_capture;
      logic      med_capture;
      logic      mid_single;
      logic      mad_capture;
      logic      keep_clear;
      logic      keep_acc;
      logic      div_start;
      logic      anchor_capture;
      logic      zero_result;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic     need_swap;
      logic     div_done;
   } status_type;
endpackage

// File: hdl/rsem_divider.sv
// Restoring divider, one quotient bit per cycle, for the kept-gap mean.
module rsem_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rsem_pkg::SumBits-1:0] dividend,
   input  logic [rsem_pkg::KeptBits:0]  divisor,
   output logic                       done,
   output logic [rsem_pkg::SumBits-1:0] quotient
);
   import rsem_pkg::*;
   localparam int StepBits = $clog2(SumBits + 1);

   logic [SumBits-1:0]  quo_ff, quo_in;
   logic [SumBits:0]    rem_ff, rem_in;
   logic [KeptBits:0]   div_ff, div_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [SumBits:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SumBits-1:0], quo_ff[SumBits-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = StepBits'(SumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (SumBits+1)'(div_ff)) begin
            rem_in = trial - (SumBits+1)'(div_ff);
            quo_in = {quo_ff[SumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumBits-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hdl/rsem_datapath.sv
// Datapath: point, gap and deviation memories, medians, filter sums and result register.
module rsem_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rsem_pkg::cmd_type    cmd,
   input  rsem_pkg::coord_type  point_x,
   input  rsem_pkg::addr_type   wr_addr,
   output rsem_pkg::status_type status,
   output rsem_pkg::coord_type  average_spacing,
   output rsem_pkg::coord_type  median_spacing,
   output rsem_pkg::coord_type  deviation_median,
   output logic [5:0]           kept_count,
   output rsem_pkg::coord_type  anchor_x,
   output logic                 lines_valid,
   output logic                 overflow
);
   import rsem_pkg::*;

   coord_type pt_mem  [MaxPoints];
   coord_type gap_mem [MaxPoints];
   coord_type dev_mem [MaxPoints];

   coord_type rd_a_ff, rd_b_ff, gap_rd_ff;
   coord_type med_lo_ff, med_ff, mad_ff, anchor_ff;
   logic [SumBits-1:0] sum_ff;
   logic [KeptBits:0]  kept_ff;
   logic      ovf_ff;
   coord_type avg_o_ff, med_o_ff, mad_o_ff, anc_o_ff;
   logic [5:0] kept_o_ff;
   logic      valid_o_ff, ovf_o_ff;
   logic      div_done;
   logic [SumBits-1:0] quotient;
   coord_type a_val, b_val, absdev, mid_val, pick_val;
   logic [CoordBits:0] pair_sum;
   logic [CoordBits:0] thr;

   always_ff @(posedge clock) begin
      if (cmd.store_point) pt_mem[wr_addr] <= point_x;
      if (cmd.swap_wr && cmd.arr == ARR_POINT) begin
         pt_mem[cmd.addr_a] <= rd_b_ff;
         pt_mem[cmd.addr_b] <= rd_a_ff;
      end
      if (cmd.swap_wr && cmd.arr == ARR_DEV) begin
         dev_mem[cmd.addr_a] <= rd_b_ff;
         dev_mem[cmd.addr_b] <= rd_a_ff;
      end
      if (cmd.gap_wr) gap_mem[cmd.addr_a] <= rd_b_ff - rd_a_ff;
      if (cmd.dev_copy_wr) dev_mem[cmd.addr_a] <= rd_b_ff - rd_a_ff;
      if (cmd.dev_abs_wr) dev_mem[cmd.addr_a] <= absdev;
      if (cmd.rd_en) begin
         if (cmd.arr == ARR_POINT) begin
            rd_a_ff <= pt_mem[cmd.addr_a];
            rd_b_ff <= pt_mem[cmd.addr_b];
         end else begin
            rd_a_ff <= dev_mem[cmd.addr_a];
            rd_b_ff <= dev_mem[cmd.addr_b];
         end
         gap_rd_ff <= gap_mem[cmd.addr_a];
      end
   end

   assign a_val    = rd_a_ff;
   assign b_val    = rd_b_ff;
   assign absdev   = (gap_rd_ff >= med_ff) ? gap_rd_ff - med_ff : med_ff - gap_rd_ff;
   assign pair_sum = {1'b0, med_lo_ff} + {1'b0, b_val};
   assign mid_val  = pair_sum[CoordBits:1];
   assign pick_val = cmd.mid_single ? b_val : mid_val;
   assign thr      = {mad_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.med_lo_capture) med_lo_ff <= b_val;
      if (cmd.med_capture)    med_ff <= pick_val;
      if (cmd.mad_capture)    mad_ff <= pick_val;
      if (cmd.anchor_capture) anchor_ff <= b_val;
      if (cmd.keep_clear) begin
         sum_ff  <= '0;
         kept_ff <= '0;
      end else if (cmd.keep_acc && {1'b0, absdev} <= thr) begin
         sum_ff  <= sum_ff + SumBits'(gap_rd_ff);
         kept_ff <= kept_ff + 1'b1;
      end
   end

   rsem_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(sum_ff),
      .divisor(kept_ff), .done(div_done), .quotient(quotient)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_set) ovf_ff <= 1'b0;
      else if (cmd.set_overflow)  ovf_ff <= 1'b1;
      if (cmd.out_load) begin
         ovf_o_ff <= ovf_ff;
         if (cmd.zero_result) begin
            avg_o_ff <= '0; med_o_ff <= '0; mad_o_ff <= '0; anc_o_ff <= '0;
            kept_o_ff <= '0; valid_o_ff <= 1'b0;
         end else begin
            avg_o_ff   <= (kept_ff == '0) ? '0 : quotient[CoordBits-1:0];
            med_o_ff   <= med_ff;
            mad_o_ff   <= mad_ff;
            anc_o_ff   <= anchor_ff;
            kept_o_ff  <= kept_ff[5:0];
            valid_o_ff <= (kept_ff != '0) && (quotient != '0);
         end
      end
   end

   assign status.need_swap = a_val > b_val;
   assign status.div_done  = div_done;
   assign average_spacing  = avg_o_ff;
   assign median_spacing   = med_o_ff;
   assign deviation_median = mad_o_ff;
   assign kept_count       = kept_o_ff;
   assign anchor_x         = anc_o_ff;
   assign lines_valid      = valid_o_ff;
   assign overflow         = ovf_o_ff;
endmodule

// File: hdl/rsem_controller.sv
// Controller state machine sequencing load, sort, median, filter and divide steps.
module rsem_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_point,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsem_pkg::status_type status,
   output rsem_pkg::cmd_type    cmd,
   output rsem_pkg::addr_type   wr_addr
);
   import rsem_pkg::*;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   count_type len_ff, len_in;        // length of the array being sorted
   count_type i_ff, i_in, j_ff, j_in;
   logic      second_ff, second_in;  // sorts now act on the deviation memory
   logic      dev_pass_ff, dev_pass_in;  // absolute deviations are in place
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   count_type ngaps;

   assign ngaps   = count_ff - 1'b1;
   assign accept  = req_valid && !req_stall;
   assign wr_addr = count_ff[AddrBits-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      second_in    = second_ff;
      dev_pass_in  = dev_pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.arr      = ARR_POINT;
      req_stall    = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (accept) begin
               if (count_ff < count_type'(MaxPoints)) begin
                  cmd.store_point = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  cmd.set_overflow = 1'b1;
               end
               if (req_last_point) begin
                  len_in = (count_ff < count_type'(MaxPoints)) ? count_ff + 1'b1 : count_ff;
                  i_in = count_type'(1);
                  j_in = count_type'(1);
                  second_in = 1'b0;
                  dev_pass_in = 1'b0;
                  state_in = ST_SORT_RD;
               end
            end
         end
         // Insertion sort: compare a[j-1] with a[j], swap and step down.
         ST_SORT_RD: begin
            if (i_ff >= len_ff) begin
               if (!second_ff) begin
                  if (len_ff < count_type'(2)) begin
                     state_in = ST_OUT;
                  end else begin
                     i_in = '0;
                     state_in = ST_GAP_RD;
                  end
               end else if (!dev_pass_ff) begin
                  state_in = ST_MED_RD;
               end else begin
                  state_in = ST_MAD_RD;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.arr    = second_ff ? ARR_DEV : ARR_POINT;
               cmd.addr_a = AddrBits'(j_ff - 1'b1);
               cmd.addr_b = j_ff[AddrBits-1:0];
               state_in   = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            cmd.arr    = second_ff ? ARR_DEV : ARR_POINT;
            cmd.addr_a = AddrBits'(j_ff - 1'b1);
            cmd.addr_b = j_ff[AddrBits-1:0];
            if (status.need_swap) begin
               cmd.swap_wr = 1'b1;
               if (j_ff == count_type'(1)) begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff - 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + 1'b1;
            end
            state_in = ST_SORT_RD;
         end
         // Gaps into gap memory and a copy into deviation memory.
         ST_GAP_RD: begin
            if (i_ff >= ngaps) begin
               len_in = ngaps;
               i_in = count_type'(1);
               j_in = count_type'(1);
               second_in = 1'b1;
               state_in = ST_SORT_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.addr_a = i_ff[AddrBits-1:0];
               cmd.addr_b = AddrBits'(i_ff + 1'b1);
               state_in   = ST_GAP_WR;
            end
         end
         ST_GAP_WR: begin
            cmd.addr_a = i_ff[AddrBits-1:0];
            cmd.gap_wr = 1'b1;
            cmd.dev_copy_wr = 1'b1;
            i_in = i_ff + 1'b1;
            state_in = ST_GAP_RD;
         end
         // Middle of sorted deviation memory; even length reads two entries.
         ST_MED_RD, ST_MAD_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.arr    = ARR_DEV;
            if (!len_ff[0] && i_ff != count_type'(0))
               cmd.addr_b = AddrBits'((len_ff >> 1) - 1'b1);
            else
               cmd.addr_b = AddrBits'(len_ff >> 1);
            state_in = (state_ff == ST_MED_RD) ? ST_MED_WR : ST_MAD_WR;
         end
         ST_MED_WR, ST_MAD_WR: begin
            // Odd length: take the one entry. Even: first the lower, then average.
            if (len_ff[0] || i_ff == count_type'(0)) begin
               cmd.mid_single  = len_ff[0];
               cmd.med_capture = (state_ff == ST_MED_WR);
               cmd.mad_capture = (state_ff == ST_MAD_WR);
               cmd.keep_clear  = (state_ff == ST_MAD_WR);
               i_in = '0;
               state_in = (state_ff == ST_MED_WR) ? ST_DEV_RD : ST_KEEP_RD;
            end else begin
               cmd.med_lo_capture = 1'b1;
               i_in = '0;
               state_in = (state_ff == ST_MED_WR) ? ST_MED_RD : ST_MAD_RD;
            end
         end
         ST_DEV_RD: begin
            if (i_ff >= len_ff) begin
               i_in = count_type'(1);
               j_in = count_type'(1);
               dev_pass_in = 1'b1;
               state_in = ST_SORT_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.arr    = ARR_DEV;
               cmd.addr_a = i_ff[AddrBits-1:0];
               state_in   = ST_DEV_WR;
            end
         end
         ST_DEV_WR: begin
            cmd.addr_a = i_ff[AddrBits-1:0];
            cmd.dev_abs_wr = 1'b1;
            i_in = i_ff + 1'b1;
            state_in = ST_DEV_RD;
         end
         ST_KEEP_RD: begin
            if (i_ff >= len_ff) begin
               state_in = ST_ANCHOR_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.addr_a = i_ff[AddrBits-1:0];
               state_in   = ST_KEEP_ACC;
            end
         end
         ST_KEEP_ACC: begin
            cmd.keep_acc = 1'b1;
            i_in = i_ff + 1'b1;
            state_in = ST_KEEP_RD;
         end
         // The divider starts here; the anchor read runs beside it.
         ST_ANCHOR_RD: begin
            cmd.div_start = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.addr_b = AddrBits'(count_ff >> 1);
            state_in   = ST_ANCHOR_WR;
         end
         ST_ANCHOR_WR: begin
            cmd.anchor_capture = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.out_load = 1'b1;
               cmd.zero_result = count_ff < count_type'(2);
               cmd.clear_set = 1'b1;
               rsp_valid_in = 1'b1;
               count_in = '0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      second_ff   <= second_in;
      dev_pass_ff <= dev_pass_in;
   end

   assign rsp_valid = rsp_valid_ff;

   a_stall_in_work: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> req_stall) else $error("input taken during work");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MaxPoints)) else $error("point count past capacity");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("result dropped");
endmodule

// File: hdl/robust_spacing_estimate_mad.sv
// Top level of the robust spacing estimator.
//
// Points enter on the req_ channel, one transaction each; req_last_point
// marks the final point of a set and starts the computation. Up to 64
// points are stored; further points are dropped and the overflow flag set.
// Loading accepts one point per cycle. After the last point req_stall stays
// high while the block sorts points, forms gaps, sorts them for the median,
// forms and sorts absolute deviations, filters and divides. Three insertion
// sorts set the latency, each compare passing through ST_SORT_RD and
// ST_SORT_CMP; the divider starts beside the anchor read. A set of fewer
// than two points skips this work; its result is all zeros but overflow.
// One result transaction appears on the rsp_ channel; it stays in its
// output register while rsp_stall is high, and the next set can load
// meanwhile, but its own result waits until that one is taken.
// Reset clears the count, the internal overflow flag and valid.
module robust_spacing_estimate_mad (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rsem_pkg::coord_type req_point_x,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsem_pkg::coord_type rsp_average_spacing,
   output rsem_pkg::coord_type rsp_median_spacing,
   output rsem_pkg::coord_type rsp_deviation_median,
   output logic [5:0]          rsp_kept_count,
   output rsem_pkg::coord_type rsp_anchor_x,
   output logic                rsp_lines_valid,
   output logic                rsp_overflow
);
   import rsem_pkg::*;

   cmd_type    cmd;
   status_type status;
   addr_type   wr_addr;

   rsem_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_last_point(req_last_point), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
      .cmd(cmd), .wr_addr(wr_addr)
   );

   rsem_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .point_x(req_point_x),
      .wr_addr(wr_addr), .status(status),
      .average_spacing(rsp_average_spacing), .median_spacing(rsp_median_spacing),
      .deviation_median(rsp_deviation_median), .kept_count(rsp_kept_count),
      .anchor_x(rsp_anchor_x), .lines_valid(rsp_lines_valid),
      .overflow(rsp_overflow)
   );
endmodule
